[hw/rtl/assert_macros.svh]
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/sspq_pkg.sv]
// types and constants of the stable sorted priority queue
package sspq_pkg;

   // number of slots in the chain
   localparam int unsigned DEPTH = 16;
   localparam int unsigned COUNT_WIDTH = $clog2(DEPTH + 1);

   // request mode codes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_POP    = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // one stored entry
   typedef struct packed {
      logic [7:0]  key;
      logic [15:0] ident;
      logic [7:0]  aux;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic      insert_en;
      logic      pop_en;
      entry_type new_entry;
   } cmd_type;

endpackage

[hw/rtl/sspq_cell.sv]
// one slot of the sorted chain with its compare and shift selection
module sspq_cell (
   input  logic               clock,
   input  sspq_pkg::cmd_type  cmd,
   input  logic               occupied,
   input  sspq_pkg::entry_type left_entry,
   input  logic               left_le,
   input  sspq_pkg::entry_type right_entry,
   output sspq_pkg::entry_type slot_entry,
   output logic               le
);
   import sspq_pkg::*;

   entry_type slot_ff;

   // stored key is not above the incoming key, so this slot stays put
   assign le = occupied && (slot_ff.key <= cmd.new_entry.key);
   assign slot_entry = slot_ff;

   // keep, take the new entry, or shift from a neighbour
   always_ff @(posedge clock) begin
      if (cmd.insert_en) begin
         if (le) begin
            slot_ff <= slot_ff;
         end else if (left_le) begin
            slot_ff <= cmd.new_entry;
         end else begin
            slot_ff <= left_entry;
         end
      end else if (cmd.pop_en) begin
         slot_ff <= right_entry;
      end
   end

endmodule

[hw/rtl/stable_sorted_priority_queue.sv]
// top level of the stable sorted priority queue: cell chain, count and result register
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_mode, req_entry_key/ident/aux
//   rsp     | out       | rsp_valid, rsp_ready, rsp_status, rsp_head_key/ident/aux,
//           |           | rsp_occupancy
//
// all cells compare against the new key in parallel and shift at the edge that accepts
// the item; the result is registered in the output register at that same edge.
// a new item is accepted while the output register is empty or being emptied.
// reset clears the entry count and the output valid; slot contents are not reset.
// a stalled result holds the request side until it is taken.
`include "assert_macros.svh"

module stable_sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_entry_key,
   input  logic [15:0] req_entry_ident,
   input  logic [7:0]  req_entry_aux,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_head_key,
   output logic [15:0] rsp_head_ident,
   output logic [7:0]  rsp_head_aux,
   output logic [4:0]  rsp_occupancy
);
   import sspq_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   status_type             status_ff;
   status_type             status_in;
   entry_type              head_ff;
   entry_type              head_in;
   logic [4:0]             occupancy_ff;

   logic      req_fire;
   logic      is_full;
   logic      is_empty;
   cmd_type   cmd;

   logic [DEPTH-1:0] occupied;
   logic [DEPTH-1:0] le;
   entry_type        slots [DEPTH];

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty  = (count_ff == '0);

   // command to the chain
   assign cmd.insert_en       = req_fire && (req_mode == MODE_INSERT) && !is_full;
   assign cmd.pop_en          = req_fire && (req_mode == MODE_POP) && !is_empty;
   assign cmd.new_entry.key   = req_entry_key;
   assign cmd.new_entry.ident = req_entry_ident;
   assign cmd.new_entry.aux   = req_entry_aux;

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;
      logic      left_le;

      assign occupied[i] = (count_ff > COUNT_WIDTH'(i));

      if (i == 0) begin : g_first
         assign left_entry = cmd.new_entry;
         assign left_le    = 1'b1;
      end else begin : g_inner
         assign left_entry = slots[i-1];
         assign left_le    = le[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = slots[i];
      end else begin : g_mid
         assign right_entry = slots[i+1];
      end

      sspq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied[i]),
         .left_entry  (left_entry),
         .left_le     (left_le),
         .right_entry (right_entry),
         .slot_entry  (slots[i]),
         .le          (le[i])
      );
   end

   // count and result selection
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = STATUS_DONE;
      head_in      = '0;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         if (req_mode == MODE_INSERT) begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end else begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               head_in  = slots[0];
               count_in = count_ff - 1'b1;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff    <= status_in;
         head_ff      <= head_in;
         occupancy_ff <= 5'(count_in);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_head_key   = head_ff.key;
   assign rsp_head_ident = head_ff.ident;
   assign rsp_head_aux   = head_ff.aux;
   assign rsp_occupancy  = occupancy_ff;

   // checks
   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= COUNT_WIDTH'(DEPTH), "count above depth")
   `ASSERT_CLK(a_full_reject, clock, reset, (req_fire && (req_mode == MODE_INSERT) && is_full) |=> (status_ff == STATUS_FULL && count_ff == $past(count_ff)), "full insert not rejected")
   `ASSERT_CLK(a_pop_count, clock, reset, (req_fire && (req_mode == MODE_POP) && !is_empty) |=> (count_ff == $past(count_ff) - 1'b1), "pop did not lower count")
   `ASSERT_CLK(a_zero_head, clock, reset, (rsp_valid_ff && (status_ff != STATUS_DONE)) |-> (head_ff == '0), "head fields not zero on error status")

endmodule

[dv/sspq_order_checker.sv]
// checker for the stable sorted priority queue: tracks the queue contents and compares every result
module sspq_order_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_entry_key,
   input  logic [15:0] req_entry_ident,
   input  logic [7:0]  req_entry_aux,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [7:0]  rsp_head_key,
   input  logic [15:0] rsp_head_ident,
   input  logic [7:0]  rsp_head_aux,
   input  logic [4:0]  rsp_occupancy,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import sspq_pkg::*;

   // what one item is predicted to return
   typedef struct packed {
      status_type             status;
      entry_type              head;
      logic [COUNT_WIDTH-1:0] occupancy;
   } outcome_type;

   // queue contents in service order, head first
   entry_type   queued_entries[$];
   // results still owed by the block, oldest first
   outcome_type owed_outcomes[$];

   // apply one item to the tracked queue and return what it should yield
   function automatic outcome_type serve_item(logic mode, entry_type item);
      outcome_type res;
      int          pos;
      res = '0;
      res.status = STATUS_DONE;
      if (mode == MODE_INSERT) begin
         if (queued_entries.size() >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // goes behind every entry with a key not above its own
            pos = 0;
            while (pos < queued_entries.size() && queued_entries[pos].key <= item.key)
               pos++;
            queued_entries.insert(pos, item);
         end
      end else if (queued_entries.size() == 0) begin
         res.status = STATUS_EMPTY;
      end else begin
         res.head = queued_entries.pop_front();
      end
      res.occupancy = COUNT_WIDTH'(queued_entries.size());
      return res;
   endfunction

   task automatic report_failure(string msg);
      $display("%0t ns: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // compare results, then record the item taken at this edge
   always @(posedge clock) begin
      outcome_type want;
      entry_type   item;
      if (reset) begin
         queued_entries.delete();
         owed_outcomes.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_outcomes.size() == 0) begin
               report_failure($sformatf("result with none awaited: status %0d occupancy %0d",
                                        rsp_status, rsp_occupancy));
            end else begin
               want = owed_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_failure($sformatf("status got %0d want %0d",
                                           rsp_status, want.status));
               if (rsp_head_key !== want.head.key)
                  report_failure($sformatf("head key got %0d want %0d",
                                           rsp_head_key, want.head.key));
               if (rsp_head_ident !== want.head.ident)
                  report_failure($sformatf("head ident got %0d want %0d",
                                           rsp_head_ident, want.head.ident));
               if (rsp_head_aux !== want.head.aux)
                  report_failure($sformatf("head aux got %0d want %0d",
                                           rsp_head_aux, want.head.aux));
               if (rsp_occupancy !== want.occupancy)
                  report_failure($sformatf("occupancy got %0d want %0d",
                                           rsp_occupancy, want.occupancy));
            end
         end
         if (req_valid && req_ready) begin
            item.key   = req_entry_key;
            item.ident = req_entry_ident;
            item.aux   = req_entry_aux;
            owed_outcomes.push_back(serve_item(req_mode, item));
         end
      end
      outstanding <= owed_outcomes.size();
   end

endmodule

[dv/stable_sorted_priority_queue_test.sv]
// top of the priority queue testbench: clock, reset, item stimulus, watchdog and verdict
module stable_sorted_priority_queue_test;
   timeunit 1ns;
   timeprecision 1ps;
   import sspq_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int PHASE_ITEMS = 250;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [7:0]  req_entry_key;
   logic [15:0] req_entry_ident;
   logic [7:0]  req_entry_aux;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_head_key;
   logic [15:0] rsp_head_ident;
   logic [7:0]  rsp_head_aux;
   logic [4:0]  rsp_occupancy;

   int mismatch_count;
   int outstanding;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   stable_sorted_priority_queue u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_entry_key   (req_entry_key),
      .req_entry_ident (req_entry_ident),
      .req_entry_aux   (req_entry_aux),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_head_key    (rsp_head_key),
      .rsp_head_ident  (rsp_head_ident),
      .rsp_head_aux    (rsp_head_aux),
      .rsp_occupancy   (rsp_occupancy)
   );

   sspq_order_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_entry_key   (req_entry_key),
      .req_entry_ident (req_entry_ident),
      .req_entry_aux   (req_entry_aux),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_head_key    (rsp_head_key),
      .rsp_head_ident  (rsp_head_ident),
      .rsp_head_aux    (rsp_head_aux),
      .rsp_occupancy   (rsp_occupancy),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // give up when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // offer one item, with optional idle cycles first, and hold it until taken
   task automatic offer_item(logic mode, logic [7:0] key, logic [15:0] ident, logic [7:0] aux);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_entry_key   <= key;
      req_entry_ident <= ident;
      req_entry_aux   <= aux;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // keys bunch on a few values so ties are common, with the extremes thrown in
   function automatic logic [7:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15)
         return $urandom_range(1) ? 8'hFF : 8'h00;
      else if (sel < 55)
         return 8'($urandom_range(3));
      else
         return 8'($urandom);
   endfunction

   initial begin
      int insert_pct;
      logic mode;
      quiet_cycles    = 0;
      send_idle_pct   = 17;
      recv_idle_pct   = 75;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_INSERT;
      req_entry_key   <= '0;
      req_entry_ident <= '0;
      req_entry_aux   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop with stray fields, fill with extremes and ties, overflow, drain a bit
      offer_item(MODE_POP,    8'hFF, 16'hFFFF, 8'hFF);
      offer_item(MODE_INSERT, 8'hFF, 16'hFFFF, 8'hFF);
      offer_item(MODE_INSERT, 8'h00, 16'h0000, 8'h00);
      offer_item(MODE_INSERT, 8'h80, 16'h8001, 8'h81);
      offer_item(MODE_INSERT, 8'h07, 16'h0001, 8'h11);
      offer_item(MODE_INSERT, 8'h07, 16'h0002, 8'h22);
      offer_item(MODE_INSERT, 8'h07, 16'h0003, 8'h33);
      offer_item(MODE_INSERT, 8'h00, 16'hAAAA, 8'h55);
      offer_item(MODE_INSERT, 8'hFF, 16'h5555, 8'hAA);
      offer_item(MODE_INSERT, 8'h07, 16'h0004, 8'h44);
      offer_item(MODE_INSERT, 8'h01, 16'h1234, 8'h01);
      offer_item(MODE_INSERT, 8'hFE, 16'hFEDC, 8'hFE);
      offer_item(MODE_INSERT, 8'h7F, 16'h7FFF, 8'h7F);
      offer_item(MODE_INSERT, 8'h00, 16'hFFFF, 8'hFF);
      offer_item(MODE_INSERT, 8'h80, 16'h8002, 8'h82);
      offer_item(MODE_INSERT, 8'h55, 16'h0F0F, 8'hF0);
      offer_item(MODE_INSERT, 8'hAA, 16'hF0F0, 8'h0F);
      offer_item(MODE_INSERT, 8'h00, 16'hBEEF, 8'h99);
      offer_item(MODE_POP,    8'h00, 16'h0000, 8'h00);
      offer_item(MODE_POP,    8'hFF, 16'hFFFF, 8'hFF);
      offer_item(MODE_INSERT, 8'h00, 16'hCAFE, 8'h66);
      offer_item(MODE_POP,    8'h00, 16'h0000, 8'h00);

      // random: three back-pressure phases, insert bias changing in bursts
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         insert_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 30 == 0) begin
               case ($urandom_range(3))
                  0: insert_pct = 25;
                  1: insert_pct = 50;
                  2: insert_pct = 75;
                  default: insert_pct = 95;
               endcase
            end
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_POP;
            offer_item(mode, pick_key(), 16'($urandom), 8'($urandom));
         end
      end
      req_valid <= 1'b0;

      // drain, then allow the output register to settle
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
